### rtl/smvt_pkg.sv
// -----------------------------------------------------------------------------
// smvt_pkg
// Shared constants, codes and types of the multiplicity veto trigger.
// -----------------------------------------------------------------------------
package smvt_pkg;

   // Channel grids.
   localparam int MAIN_ROWS      = 4;
   localparam int MAIN_COLS      = 4;
   localparam int CONT_ROWS      = 4;
   localparam int CONT_COLS      = 4;
   localparam int MAIN_CHANNELS  = MAIN_ROWS * MAIN_COLS;
   localparam int CONT_CHANNELS  = CONT_ROWS * CONT_COLS;
   localparam int MAX_CHANNELS   = (MAIN_CHANNELS > CONT_CHANNELS) ? MAIN_CHANNELS
                                                                   : CONT_CHANNELS;
   localparam int CH_W           = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int MAIN_IDX_W     = (MAIN_CHANNELS > 1) ? $clog2(MAIN_CHANNELS) : 1;
   localparam int CONT_IDX_W     = (CONT_CHANNELS > 1) ? $clog2(CONT_CHANNELS) : 1;
   localparam int POP_W          = $clog2(MAIN_CHANNELS + 1);

   // Photon count cuts.
   localparam int NUM_CUTS       = 5;
   localparam int CUT_IDX_W      = $clog2(NUM_CUTS);
   localparam int STEP_W         = $clog2(NUM_CUTS + 1);

   // Region of interest window in eV, both bounds exclusive.
   localparam logic [31:0] ROI_LOW_EV  = 32'd2000000;
   localparam logic [31:0] ROI_HIGH_EV = 32'd2100000;

   // Register reset values.
   localparam logic [15:0] CUT_A_RESET     = 16'd1;
   localparam logic [15:0] CUT_B_RESET     = 16'd3;
   localparam logic [15:0] CUT_C_RESET     = 16'd5;
   localparam logic [15:0] CUT_D_RESET     = 16'd7;
   localparam logic [15:0] CUT_E_RESET     = 16'd10;
   localparam logic [31:0] THRESHOLD_RESET = 32'd10;
   localparam logic [7:0]  MIN_SIG_RESET   = 8'd2;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request kinds carried on req_tuser.
   typedef enum logic [2:0] {
      OP_BEGIN    = 3'd0,
      OP_ENERGY   = 3'd1,
      OP_PHOTON   = 3'd2,
      OP_MAIN_SIG = 3'd3,
      OP_CONT_SIG = 3'd4,
      OP_END      = 3'd5
   } op_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_CUT_A     = 3'd0,
      CSR_CUT_B     = 3'd1,
      CSR_CUT_C     = 3'd2,
      CSR_CUT_D     = 3'd3,
      CSR_CUT_E     = 3'd4,
      CSR_THRESHOLD = 3'd5,
      CSR_MIN_SIG   = 3'd6
   } csr_index_type;

   typedef struct packed {
      op_type            op;
      logic [CH_W-1:0]   chan;
      logic [23:0]       energy;
      logic              detectable;
   } cmd_type;

   typedef struct packed {
      logic [NUM_CUTS-1:0][15:0] cut;
      logic [31:0]               threshold;
      logic [7:0]                min_signal;
   } cfg_type;

endpackage

### rtl/sipm_multiplicity_veto_trigger_unit.sv
// -----------------------------------------------------------------------------
// sipm_multiplicity_veto_trigger_unit
// Gathers one detector event and emits its veto and region flags at event end.
// -----------------------------------------------------------------------------
// Requests enter a four-entry command queue, one per cycle while the queue has
// room. The back end retires a begin, energy, photon or signal request as it
// pops it. An end request takes the back end from run through scan and emit:
// the scan compares the per-channel photon counts against the five cuts one
// cut per cycle and counts the passing channels, and emit loads the output
// register once it is free; that register holds the result until it is taken.
// Requests keep queuing during that time. Unused request kinds and channels
// outside their grid are taken and have no effect. Registers are written
// through the csr port, which is always ready.
module sipm_multiplicity_veto_trigger_unit import smvt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] func
   input  logic [31:0] req_tdata,   // [1:0] row, [3:2] col, [27:4] energy,
                                    // [28] detectable, [31:29] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [0] veto, [5:1] veto_cut_mask, [6] bulk_event,
                                    // [7] sipm_event, [8] detectable_event,
                                    // [9] veto_possible, [10] roi_event,
                                    // [11] roi_veto, [12] roi_veto_possible,
                                    // [44:13] bulk_energy, [52:45] signal_channels,
                                    // [55:53] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   cmd_type q_cmd;
   cmd_type q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CUT_A:     cfg_in.cut[0]      = csr_data[15:0];
            CSR_CUT_B:     cfg_in.cut[1]      = csr_data[15:0];
            CSR_CUT_C:     cfg_in.cut[2]      = csr_data[15:0];
            CSR_CUT_D:     cfg_in.cut[3]      = csr_data[15:0];
            CSR_CUT_E:     cfg_in.cut[4]      = csr_data[15:0];
            CSR_THRESHOLD: cfg_in.threshold   = csr_data;
            CSR_MIN_SIG:   cfg_in.min_signal  = csr_data[7:0];
            default:       cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cut[0]     <= CUT_A_RESET;
         cfg_ff.cut[1]     <= CUT_B_RESET;
         cfg_ff.cut[2]     <= CUT_C_RESET;
         cfg_ff.cut[3]     <= CUT_D_RESET;
         cfg_ff.cut[4]     <= CUT_E_RESET;
         cfg_ff.threshold  <= THRESHOLD_RESET;
         cfg_ff.min_signal <= MIN_SIG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   smvt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   smvt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   smvt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/smvt_front.sv
// -----------------------------------------------------------------------------
// smvt_front
// Accepts requests, checks grid bounds and turns them into queue commands.
// -----------------------------------------------------------------------------
module smvt_front import smvt_pkg::*; (
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // func
   input  logic [31:0] req_tdata,   // row, col, energy, detectable
   input  logic        q_full,
   output logic        q_push,
   output cmd_type     q_cmd
);

   logic [1:0] row;
   logic [1:0] col;
   logic       in_main;
   logic       in_cont;
   logic       fire;

   assign row  = req_tdata[1:0];
   assign col  = req_tdata[3:2];
   assign req_tready = !q_full;
   assign fire = req_tvalid && !q_full;

   assign in_main = (32'(row) < MAIN_ROWS) && (32'(col) < MAIN_COLS);
   assign in_cont = (32'(row) < CONT_ROWS) && (32'(col) < CONT_COLS);

   always_comb begin
      q_cmd.op         = OP_BEGIN;
      q_cmd.chan       = '0;
      q_cmd.energy     = req_tdata[27:4];
      q_cmd.detectable = req_tdata[28];
      q_push           = 1'b0;
      case (req_tuser)
         OP_BEGIN: begin
            q_cmd.op = OP_BEGIN;
            q_push   = fire;
         end
         OP_ENERGY: begin
            q_cmd.op = OP_ENERGY;
            q_push   = fire;
         end
         OP_PHOTON: begin
            q_cmd.op   = OP_PHOTON;
            q_cmd.chan = CH_W'(32'(row) * MAIN_COLS + 32'(col));
            q_push     = fire && in_main;
         end
         OP_MAIN_SIG: begin
            q_cmd.op   = OP_MAIN_SIG;
            q_cmd.chan = CH_W'(32'(row) * MAIN_COLS + 32'(col));
            q_push     = fire && in_main;
         end
         OP_CONT_SIG: begin
            q_cmd.op   = OP_CONT_SIG;
            q_cmd.chan = CH_W'(32'(row) * CONT_COLS + 32'(col));
            q_push     = fire && in_cont;
         end
         OP_END: begin
            q_cmd.op = OP_END;
            q_push   = fire;
         end
         default: begin
            // Unused kinds are taken and dropped.
            q_push = 1'b0;
         end
      endcase
   end

endmodule

### rtl/smvt_queue.sv
// -----------------------------------------------------------------------------
// smvt_queue
// Small command FIFO that decouples the front from the back.
// -----------------------------------------------------------------------------
module smvt_queue import smvt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/smvt_back.sv
// -----------------------------------------------------------------------------
// smvt_back
// Executes commands on the event stores and builds the end-of-event result.
// -----------------------------------------------------------------------------
module smvt_back import smvt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_empty,
   input  cmd_type     q_head,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata
);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_SCAN,
      ST_EMIT
   } state_type;

   function automatic logic [POP_W-1:0] popcount(input logic [MAIN_CHANNELS-1:0] v);
      logic [POP_W-1:0] n;
      n = '0;
      for (int k = 0; k < MAIN_CHANNELS; k++) begin
         n = n + POP_W'(v[k]);
      end
      return n;
   endfunction

   // Event stores.
   logic [31:0]              energy_ff, energy_in;
   logic [15:0]              photon_ff [MAIN_CHANNELS];
   logic [15:0]              photon_in [MAIN_CHANNELS];
   logic [MAIN_CHANNELS-1:0] main_seen_ff, main_seen_in;
   logic [CONT_CHANNELS-1:0] cont_seen_ff, cont_seen_in;
   logic [7:0]               sig_mult_ff, sig_mult_in;

   // Sequencer and result.
   state_type                state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [MAIN_CHANNELS-1:0] hit_ff, hit_in;
   logic [NUM_CUTS-1:0]      mask_ff, mask_in;
   logic                     det_ff, det_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [55:0]              rsp_data_ff, rsp_data_in;

   logic [32:0]              energy_sum;
   logic [MAIN_IDX_W-1:0]    main_idx;
   logic [CONT_IDX_W-1:0]    cont_idx;
   logic [STEP_W-1:0]        prev_step;
   logic [POP_W-1:0]         hit_count;
   logic [7:0]               hit_sat;
   logic                     bulk;
   logic                     mult;
   logic                     roi;

   assign q_pop      = (state_ff == ST_RUN) && !q_empty;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign main_idx   = q_head.chan[MAIN_IDX_W-1:0];
   assign cont_idx   = q_head.chan[CONT_IDX_W-1:0];
   assign energy_sum = {1'b0, energy_ff} + 33'(q_head.energy);

   assign bulk = energy_ff > cfg.threshold;
   assign mult = sig_mult_ff >= cfg.min_signal;
   assign roi  = (energy_ff > ROI_LOW_EV) && (energy_ff < ROI_HIGH_EV);

   assign prev_step = step_ff - 1'b1;
   assign hit_count = popcount(hit_ff);
   assign hit_sat   = (32'(hit_count) > 255) ? 8'd255 : 8'(hit_count);

   // Store updates, one command per popped entry.
   always_comb begin
      energy_in    = energy_ff;
      main_seen_in = main_seen_ff;
      cont_seen_in = cont_seen_ff;
      sig_mult_in  = sig_mult_ff;
      for (int k = 0; k < MAIN_CHANNELS; k++) begin
         photon_in[k] = photon_ff[k];
      end
      if (q_pop) begin
         case (q_head.op)
            OP_BEGIN: begin
               energy_in    = '0;
               main_seen_in = '0;
               cont_seen_in = '0;
               sig_mult_in  = '0;
               for (int k = 0; k < MAIN_CHANNELS; k++) begin
                  photon_in[k] = '0;
               end
            end
            OP_ENERGY: begin
               energy_in = energy_sum[32] ? '1 : energy_sum[31:0];
            end
            OP_PHOTON: begin
               for (int k = 0; k < MAIN_CHANNELS; k++) begin
                  if (main_idx == MAIN_IDX_W'(k) && photon_ff[k] != 16'hFFFF) begin
                     photon_in[k] = photon_ff[k] + 16'd1;
                  end
               end
            end
            OP_MAIN_SIG: begin
               if (!main_seen_ff[main_idx]) begin
                  main_seen_in[main_idx] = 1'b1;
                  if (sig_mult_ff != 8'hFF) begin
                     sig_mult_in = sig_mult_ff + 8'd1;
                  end
               end
            end
            OP_CONT_SIG: begin
               if (!cont_seen_ff[cont_idx]) begin
                  cont_seen_in[cont_idx] = 1'b1;
                  if (sig_mult_ff != 8'hFF) begin
                     sig_mult_in = sig_mult_ff + 8'd1;
                  end
               end
            end
            default: begin
               energy_in = energy_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff    <= '0;
         main_seen_ff <= '0;
         cont_seen_ff <= '0;
         sig_mult_ff  <= '0;
         for (int k = 0; k < MAIN_CHANNELS; k++) begin
            photon_ff[k] <= '0;
         end
      end else begin
         energy_ff    <= energy_in;
         main_seen_ff <= main_seen_in;
         cont_seen_ff <= cont_seen_in;
         sig_mult_ff  <= sig_mult_in;
         for (int k = 0; k < MAIN_CHANNELS; k++) begin
            photon_ff[k] <= photon_in[k];
         end
      end
   end

   // The scan checks one cut per cycle against all channels; the channel count
   // of a cut is taken from its registered compare vector in the next cycle.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      hit_in       = hit_ff;
      mask_in      = mask_ff;
      det_in       = det_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_RUN: begin
            if (q_pop && q_head.op == OP_END) begin
               state_in = ST_SCAN;
               step_in  = '0;
               mask_in  = '0;
               det_in   = q_head.detectable;
            end
         end
         ST_SCAN: begin
            if (step_ff < STEP_W'(NUM_CUTS)) begin
               for (int k = 0; k < MAIN_CHANNELS; k++) begin
                  hit_in[k] = photon_ff[k] >= cfg.cut[step_ff[CUT_IDX_W-1:0]];
               end
            end
            if (step_ff != '0) begin
               mask_in[prev_step[CUT_IDX_W-1:0]] = bulk && (hit_sat >= cfg.min_signal);
            end
            if (step_ff == STEP_W'(NUM_CUTS)) begin
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, sig_mult_ff, energy_ff,
                               roi && det_ff, roi && mult, roi,
                               det_ff && (energy_ff != '0), det_ff,
                               sig_mult_ff != '0, bulk, mask_ff, bulk && mult};
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hit_ff      <= hit_in;
      mask_ff     <= mask_in;
      det_ff      <= det_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### rtl/smvt_checker.sv
// -----------------------------------------------------------------------------
// smvt_checker
// Port-level checks of the veto trigger, bound to the top level.
// -----------------------------------------------------------------------------
module smvt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // No result may survive a reset.
   a_reset_clears_result: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Every veto flag, the combined one and each cut, needs the bulk flag.
   a_veto_needs_bulk: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[0] || rsp_tdata[5:1] != 5'd0) |-> rsp_tdata[6])
      else $error("veto without bulk energy");

   a_sipm_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7] == (rsp_tdata[52:45] != 8'd0))
      else $error("sipm flag disagrees with channel count");

   a_roi_flags_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[11] || rsp_tdata[12]) |-> rsp_tdata[10])
      else $error("roi veto flag without roi event");

endmodule

bind sipm_multiplicity_veto_trigger_unit smvt_checker u_checker (.*);

### dv/tb.sv
// -----------------------------------------------------------------------------
// tb
// Self-checking testbench for the SiPM multiplicity veto trigger unit.
// -----------------------------------------------------------------------------
// Requests are queued by the stimulus process and driven by a clocked driver.
// The driver keeps its own copy of the event stores and predicts the trigger
// result of each accepted end request. A clocked monitor compares every result
// with the oldest prediction. Registers are rewritten between phases while the
// unit is quiet. The phases cover the reset settings, saturation of the energy
// sum, all-zero and all-max settings, and random ones.
// -----------------------------------------------------------------------------
module tb;
   import smvt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The two request kinds that the unit must ignore.
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   // An end request holds the back end through its scan and emit states, and up to four
   // requests may still sit in the command queue behind the last result.
   localparam int DRAIN_CYCLES = 40;
   localparam int NORMAL_IDLE  = 27;

   typedef struct {
      logic [2:0]  func;
      logic [1:0]  row;
      logic [1:0]  col;
      logic [23:0] energy;
      logic        detectable;
   } hit_item_type;

   // Fields from the top bit down, so that the result bus casts onto it.
   typedef struct packed {
      logic [7:0]  signal_channels;
      logic [31:0] bulk_energy;
      logic        roi_veto_possible;
      logic        roi_veto;
      logic        roi_event;
      logic        veto_possible;
      logic        detectable_event;
      logic        sipm_event;
      logic        bulk_event;
      logic [4:0]  veto_cut_mask;
      logic        veto;
   } trig_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_CUT_A;
   logic [31:0] csr_data = '0;

   hit_item_type    pending_requests[$];
   hit_item_type    driven_request;
   trig_result_type expected_triggers[$];

   // Predicted event stores and register settings.
   logic [15:0]  photon_tally[MAIN_CHANNELS];
   logic         main_flag[MAIN_CHANNELS];
   logic         cont_flag[CONT_CHANNELS];
   logic [31:0]  energy_acc;
   logic [7:0]   channel_mult;
   cfg_type      trig_cfg;

   int idle_pct = NORMAL_IDLE;
   int stall_pct = NORMAL_IDLE;
   int requests_queued = 0;
   int requests_accepted = 0;
   int results_checked = 0;
   int mismatches = 0;
   int settings_used = 1;
   int veto_count = 0;
   int roi_count = 0;
   int cut_pass_count = 0;

   sipm_multiplicity_veto_trigger_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic void clear_event_stores();
      int k;
      for (k = 0; k < MAIN_CHANNELS; k++) begin
         photon_tally[k] = '0;
         main_flag[k] = 1'b0;
      end
      for (k = 0; k < CONT_CHANNELS; k++) begin
         cont_flag[k] = 1'b0;
      end
      energy_acc = '0;
      channel_mult = '0;
   endfunction

   function automatic void predict_trigger(hit_item_type it);
      int unsigned     ch;
      int unsigned     passing;
      int              c;
      int              k;
      logic [32:0]     sum;
      logic            bulk;
      logic            mult;
      logic            roi;
      trig_result_type r;
      case (it.func)
         OP_BEGIN: begin
            clear_event_stores();
         end
         OP_ENERGY: begin
            sum = {1'b0, energy_acc} + it.energy;
            energy_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         end
         OP_PHOTON: begin
            if (it.row < MAIN_ROWS && it.col < MAIN_COLS) begin
               ch = it.row * MAIN_COLS + it.col;
               if (photon_tally[ch] != 16'hFFFF) photon_tally[ch]++;
            end
         end
         OP_MAIN_SIG: begin
            if (it.row < MAIN_ROWS && it.col < MAIN_COLS) begin
               ch = it.row * MAIN_COLS + it.col;
               if (!main_flag[ch]) begin
                  main_flag[ch] = 1'b1;
                  if (channel_mult != 8'hFF) channel_mult++;
               end
            end
         end
         OP_CONT_SIG: begin
            if (it.row < CONT_ROWS && it.col < CONT_COLS) begin
               ch = it.row * CONT_COLS + it.col;
               if (!cont_flag[ch]) begin
                  cont_flag[ch] = 1'b1;
                  if (channel_mult != 8'hFF) channel_mult++;
               end
            end
         end
         OP_END: begin
            bulk = energy_acc > trig_cfg.threshold;
            mult = channel_mult >= trig_cfg.min_signal;
            roi = energy_acc > ROI_LOW_EV && energy_acc < ROI_HIGH_EV;
            r = '0;
            // The cut multiplicities use the cut registers in force at the end.
            for (c = 0; c < NUM_CUTS; c++) begin
               passing = 0;
               for (k = 0; k < MAIN_CHANNELS; k++) begin
                  if (photon_tally[k] >= trig_cfg.cut[c]) passing++;
               end
               if (passing > 255) passing = 255;
               if (bulk && passing >= trig_cfg.min_signal) r.veto_cut_mask[c] = 1'b1;
            end
            r.veto = bulk && mult;
            r.bulk_event = bulk;
            r.sipm_event = channel_mult != 0;
            r.detectable_event = it.detectable;
            r.veto_possible = it.detectable && energy_acc != 0;
            r.roi_event = roi;
            r.roi_veto = roi && mult;
            r.roi_veto_possible = roi && it.detectable;
            r.bulk_energy = energy_acc;
            r.signal_channels = channel_mult;
            expected_triggers.push_back(r);
            veto_count += r.veto;
            roi_count += r.roi_event;
            cut_pass_count += (r.veto_cut_mask != 0);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic string fmt_trigger(trig_result_type r);
      return $sformatf("veto=%0b mask=%b bulk=%0b sipm=%0b det=%0b vp=%0b roi=%0b %s%0d %s%0d",
                       r.veto, r.veto_cut_mask, r.bulk_event, r.sipm_event,
                       r.detectable_event, r.veto_possible, r.roi_event,
                       $sformatf("rv=%0b rvp=%0b energy=", r.roi_veto, r.roi_veto_possible),
                       r.bulk_energy, "chans=", r.signal_channels);
   endfunction

   function automatic void check_trigger(trig_result_type got);
      trig_result_type want;
      string           bad;
      if (expected_triggers.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result with no request pending: %s", $realtime, fmt_trigger(got));
         return;
      end
      want = expected_triggers.pop_front();
      results_checked++;
      bad = "";
      if (got.veto != want.veto) bad = {bad, " veto"};
      if (got.veto_cut_mask != want.veto_cut_mask) bad = {bad, " veto_cut_mask"};
      if (got.bulk_event != want.bulk_event) bad = {bad, " bulk_event"};
      if (got.sipm_event != want.sipm_event) bad = {bad, " sipm_event"};
      if (got.detectable_event != want.detectable_event) bad = {bad, " detectable_event"};
      if (got.veto_possible != want.veto_possible) bad = {bad, " veto_possible"};
      if (got.roi_event != want.roi_event) bad = {bad, " roi_event"};
      if (got.roi_veto != want.roi_veto) bad = {bad, " roi_veto"};
      if (got.roi_veto_possible != want.roi_veto_possible) bad = {bad, " roi_veto_possible"};
      if (got.bulk_energy != want.bulk_energy) bad = {bad, " bulk_energy"};
      if (got.signal_channels != want.signal_channels) bad = {bad, " signal_channels"};
      if (bad != "") begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: result %0d differs in%s", $realtime, results_checked, bad);
            $display("   expected %s", fmt_trigger(want));
            $display("   actual   %s", fmt_trigger(got));
         end
      end
   endfunction

   // Driver: one request in flight, the next one picked when it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         clear_event_stores();
      end else begin
         if (req_tvalid && req_tready) begin
            predict_trigger(driven_request);
            requests_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
               driven_request = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= driven_request.func;
               req_tdata <= {3'b000, driven_request.detectable, driven_request.energy,
                             driven_request.col, driven_request.row};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random back pressure on the result side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_trigger(trig_result_type'(rsp_tdata[52:0]));
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic hit_item_type make_request(logic [2:0] func, logic [1:0] row,
                                                 logic [1:0] col, logic [23:0] energy,
                                                 logic detectable);
      hit_item_type it;
      it.func = func;
      it.row = row;
      it.col = col;
      it.energy = energy;
      it.detectable = detectable;
      return it;
   endfunction

   function automatic void queue_request(hit_item_type it);
      pending_requests.push_back(it);
      requests_queued++;
   endfunction

   function automatic logic [23:0] pick_deposit(int style);
      case (style)
         0: return 24'($urandom_range(0, 40));
         // Two large deposits land near the region of interest window.
         1: return ($urandom_range(99) < 50) ? 24'($urandom_range(990000, 1050005))
                                             : 24'($urandom_range(0, 20));
         2: return 24'($urandom);
         default: return 24'($urandom_range(0, 4000));
      endcase
   endfunction

   // Queues one event, mostly well formed, and returns how many requests it holds.
   function automatic int queue_random_event();
      int        added;
      int        roll;
      int        n_body;
      int        style;
      int        pick;
      int        i;
      logic [3:0] hot_a;
      logic [3:0] hot_b;
      logic [3:0] ch;
      added = 0;
      roll = $urandom_range(99);
      if (roll < 8) begin
         n_body = $urandom_range(1, 6);
         for (i = 0; i < n_body; i++) begin
            queue_request(make_request(3'($urandom_range(0, 7)), 2'($urandom), 2'($urandom),
                                       24'($urandom), 1'($urandom)));
         end
         return n_body;
      end
      // Some events start without a begin and pile onto the previous stores.
      if (roll >= 12) begin
         queue_request(make_request(OP_BEGIN, 2'($urandom), 2'($urandom), 24'($urandom),
                                    1'($urandom)));
         added++;
      end
      style = $urandom_range(0, 3);
      hot_a = 4'($urandom);
      hot_b = 4'($urandom);
      n_body = $urandom_range(0, 36);
      for (i = 0; i < n_body; i++) begin
         pick = $urandom_range(99);
         ch = ($urandom_range(99) < 70) ? (($urandom_range(1) != 0) ? hot_a : hot_b)
                                        : 4'($urandom);
         if (pick < 15)
            queue_request(make_request(OP_ENERGY, ch[3:2], ch[1:0], pick_deposit(style),
                                       1'($urandom)));
         else if (pick < 65)
            queue_request(make_request(OP_PHOTON, ch[3:2], ch[1:0], 24'($urandom),
                                       1'($urandom)));
         else if (pick < 80)
            queue_request(make_request(OP_MAIN_SIG, 2'($urandom), 2'($urandom),
                                       24'($urandom), 1'($urandom)));
         else if (pick < 96)
            queue_request(make_request(OP_CONT_SIG, 2'($urandom), 2'($urandom),
                                       24'($urandom), 1'($urandom)));
         else
            queue_request(make_request(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                                       2'($urandom), 2'($urandom), 24'($urandom),
                                       1'($urandom)));
      end
      added += n_body;
      pick = $urandom_range(99);
      if (pick < 94) begin
         queue_request(make_request(OP_END, 2'($urandom), 2'($urandom), 24'($urandom),
                                    1'($urandom)));
         added++;
      end
      if (pick < 10) begin
         queue_request(make_request(OP_END, 2'($urandom), 2'($urandom), 24'($urandom),
                                    1'($urandom)));
         added++;
      end
      return added;
   endfunction

   // Returns once every queued request is taken, every result has come back
   // and the requests behind the last result have had time to retire.
   task automatic wait_quiet();
      while (requests_accepted != requests_queued) @(posedge clock);
      while (expected_triggers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high from one write to the next; the caller lowers it.
   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CUT_A:     trig_cfg.cut[0] = value[15:0];
         CSR_CUT_B:     trig_cfg.cut[1] = value[15:0];
         CSR_CUT_C:     trig_cfg.cut[2] = value[15:0];
         CSR_CUT_D:     trig_cfg.cut[3] = value[15:0];
         CSR_CUT_E:     trig_cfg.cut[4] = value[15:0];
         CSR_THRESHOLD: trig_cfg.threshold = value;
         CSR_MIN_SIG:   trig_cfg.min_signal = value[7:0];
         default: begin
         end
      endcase
   endtask

   task automatic apply_settings(logic [4:0][15:0] cuts, logic [31:0] threshold,
                                 logic [7:0] min_signal);
      @(posedge clock);
      write_csr(CSR_CUT_A, cuts[0]);
      write_csr(CSR_CUT_B, cuts[1]);
      write_csr(CSR_CUT_C, cuts[2]);
      write_csr(CSR_CUT_D, cuts[3]);
      write_csr(CSR_CUT_E, cuts[4]);
      write_csr(CSR_THRESHOLD, threshold);
      write_csr(CSR_MIN_SIG, min_signal);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random_phase(int target);
      int added;
      added = 0;
      while (added < target) added += queue_random_event();
      wait_quiet();
   endtask

   task automatic apply_random_settings();
      logic [4:0][15:0] cuts;
      int               c;
      for (c = 0; c < NUM_CUTS; c++) cuts[c] = 16'($urandom_range(0, 12));
      apply_settings(cuts, 32'($urandom_range(0, 2500000)), 8'($urandom_range(0, 4)));
   endtask

   initial begin
      int i;
      trig_cfg.cut[0] = CUT_A_RESET;
      trig_cfg.cut[1] = CUT_B_RESET;
      trig_cfg.cut[2] = CUT_C_RESET;
      trig_cfg.cut[3] = CUT_D_RESET;
      trig_cfg.cut[4] = CUT_E_RESET;
      trig_cfg.threshold = THRESHOLD_RESET;
      trig_cfg.min_signal = MIN_SIG_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset settings.
      queue_request(make_request(OP_MAIN_SIG, 2'd0, 2'd0, 24'd0, 1'b0));
      queue_request(make_request(OP_END, 2'd3, 2'd3, 24'hFFFFFF, 1'b1));
      queue_request(make_request(OP_BEGIN, 2'd3, 2'd3, 24'hFFFFFF, 1'b1));
      queue_request(make_request(OP_ENERGY, 2'd3, 2'd3, 24'hFFFFFF, 1'b1));
      queue_request(make_request(OP_ENERGY, 2'd0, 2'd0, 24'd0, 1'b0));
      queue_request(make_request(OP_PHOTON, 2'd3, 2'd3, 24'd0, 1'b0));
      queue_request(make_request(OP_PHOTON, 2'd3, 2'd3, 24'd0, 1'b0));
      queue_request(make_request(OP_MAIN_SIG, 2'd3, 2'd3, 24'd0, 1'b0));
      // A channel that is already flagged must not count twice.
      queue_request(make_request(OP_MAIN_SIG, 2'd3, 2'd3, 24'd0, 1'b0));
      queue_request(make_request(OP_CONT_SIG, 2'd3, 2'd3, 24'd0, 1'b0));
      queue_request(make_request(OP_SPARE_LO, 2'd2, 2'd1, 24'hABCDEF, 1'b1));
      queue_request(make_request(OP_SPARE_HI, 2'd1, 2'd2, 24'h123456, 1'b0));
      queue_request(make_request(OP_END, 2'd0, 2'd0, 24'd0, 1'b0));
      queue_request(make_request(OP_END, 2'd0, 2'd0, 24'd0, 1'b1));
      // Both edges of the region of interest window are exclusive.
      queue_request(make_request(OP_BEGIN, 2'd0, 2'd0, 24'd0, 1'b1));
      queue_request(make_request(OP_ENERGY, 2'd0, 2'd0, ROI_LOW_EV[23:0], 1'b1));
      queue_request(make_request(OP_END, 2'd0, 2'd0, 24'd0, 1'b1));
      queue_request(make_request(OP_ENERGY, 2'd0, 2'd0, 24'd1, 1'b1));
      queue_request(make_request(OP_END, 2'd0, 2'd0, 24'd0, 1'b1));
      queue_request(make_request(OP_BEGIN, 2'd0, 2'd0, 24'd0, 1'b1));
      queue_request(make_request(OP_ENERGY, 2'd0, 2'd0, ROI_HIGH_EV[23:0] - 24'd1, 1'b1));
      queue_request(make_request(OP_END, 2'd0, 2'd0, 24'd0, 1'b1));
      queue_request(make_request(OP_ENERGY, 2'd0, 2'd0, 24'd1, 1'b1));
      queue_request(make_request(OP_END, 2'd0, 2'd0, 24'd0, 1'b1));
      wait_quiet();

      // Saturation of the energy sum, with one photon counter past the low
      // cuts, run without any idling on either side.
      idle_pct = 0;
      stall_pct = 0;
      apply_settings({16'hFFFF, 16'hFFFF, 16'hFFFE, 16'd1, 16'd0}, 32'hFFFF_FFFE, 8'd1);
      queue_request(make_request(OP_BEGIN, 2'd0, 2'd0, 24'd0, 1'b0));
      for (i = 0; i < 258; i++)
         queue_request(make_request(OP_ENERGY, 2'd1, 2'd2, 24'hFFFFFF, 1'b0));
      for (i = 0; i < 12; i++)
         queue_request(make_request(OP_PHOTON, 2'd1, 2'd2, 24'd0, 1'b0));
      for (i = 0; i < MAIN_CHANNELS; i++)
         queue_request(make_request(OP_MAIN_SIG, 2'(i / MAIN_COLS), 2'(i % MAIN_COLS),
                                    24'd0, 1'b0));
      for (i = 0; i < CONT_CHANNELS; i++)
         queue_request(make_request(OP_CONT_SIG, 2'(i / CONT_COLS), 2'(i % CONT_COLS),
                                    24'd0, 1'b0));
      queue_request(make_request(OP_END, 2'd0, 2'd0, 24'd0, 1'b1));
      wait_quiet();

      // All registers at their maximum; the first end rereads the saturated stores.
      idle_pct = NORMAL_IDLE;
      stall_pct = NORMAL_IDLE;
      apply_settings({5{16'hFFFF}}, 32'hFFFF_FFFF, 8'hFF);
      queue_request(make_request(OP_END, 2'd0, 2'd0, 24'd0, 1'b1));
      run_random_phase(250);

      apply_settings('0, 32'd0, 8'd0);
      run_random_phase(320);

      apply_random_settings();
      run_random_phase(320);

      // A stretch with no idling on either side.
      idle_pct = 0;
      stall_pct = 0;
      apply_random_settings();
      run_random_phase(320);

      idle_pct = NORMAL_IDLE;
      stall_pct = NORMAL_IDLE;
      apply_random_settings();
      run_random_phase(320);

      $display("Covered %0d requests under %0d register settings, %0d trigger results checked.",
               requests_accepted, settings_used, results_checked);
      $display("Results with veto: %0d, inside the ROI window: %0d, with a cut passing: %0d.",
               veto_count, roi_count, cut_pass_count);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Hard stop far beyond the slowest correct run.
   initial begin
      #(10_000_000);
      $display("Test completed with failures");
      $finish;
   end

endmodule

### files.f
rtl/smvt_pkg.sv
rtl/smvt_front.sv
rtl/smvt_queue.sv
rtl/smvt_back.sv
rtl/sipm_multiplicity_veto_trigger_unit.sv
rtl/smvt_checker.sv
dv/tb.sv
